// ===== rtl/core/rac_pkg.sv =====
// rac_pkg: shared types, status codes and state encodings for the radix
// arithmetic converter. No dependencies.
package rac_pkg;

   localparam logic [7:0] OP_ADD = 8'h2B;
   localparam logic [7:0] OP_SUB = 8'h2D;
   localparam logic [7:0] OP_MUL = 8'h2A;
   localparam logic [7:0] OP_DIV = 8'h2F;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_OP    = 3'd1;
   localparam logic [2:0] ST_BAD_BASE  = 3'd2;
   localparam logic [2:0] ST_BAD_DIGIT = 3'd3;
   localparam logic [2:0] ST_DIV_ZERO  = 3'd4;
   localparam logic [2:0] ST_NEGATIVE  = 3'd5;
   localparam logic [2:0] ST_OVERFLOW  = 3'd6;

   localparam int unsigned NUMERAL_DIGITS = 19;
   localparam logic [30:0] RESULT_MAX     = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [7:0]  func;
      logic [3:0]  in_base;
      logic [29:0] operand_a;
      logic [29:0] operand_b;
      logic [3:0]  out_base;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [29:0] value_a;
      logic [29:0] value_b;
      logic [30:0] result_value;
      logic [63:0] result_numeral;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_DEC_A,
      S_DEC_B,
      S_MUL,
      S_DIV,
      S_RANGE,
      S_ENC,
      S_DONE
   } state_type;

endpackage

// ===== rtl/core/rac_digit_divider.sv =====
// rac_digit_divider: restoring shift-subtract divider, one quotient bit per
// cycle. Depends on nothing but its ports.
module rac_digit_divider #(
   parameter int W = 31
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quot_ff, quot_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
         end else begin
            rem_in = trial[W-1:0];
         end
         quot_in = {quot_ff[W-2:0], ~diff[W]};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;
endmodule

// ===== rtl/core/radix_arithmetic_converter_core.sv =====
// radix_arithmetic_converter_core: top level of the radix converter.
// Depends on rac_pkg and rac_digit_divider.
//
// Usage: drive req (a packed rac_pkg::req_type word) and pulse start while
// busy is low; the word is taken at that edge. busy stays high until the
// response. The result word appears on rsp for exactly one cycle with
// rsp_valid high; the receiver cannot stall it and must take it then.
//
// Latency per word is data dependent. One shared 31-bit divider (one bit
// per cycle) does all the digit work. Each operand digit costs one divide
// by ten (at most OPERAND_DIGITS per operand, plus a final step per
// operand to finish), the multiply runs bit-serially over the 30
// multiplier bits, a '/' costs one divide, and each output digit costs
// one divide by out_base (at most 19 digits, plus a final step to finish
// or flag overflow). A bad operator, base or digit count is caught in
// S_CHECK and answered from S_DONE without any divide. Words are
// processed one at a time; the next one is taken from the strobe cycle.
//
// Reset (synchronous, active high) returns the sequencer to idle and drops
// busy and rsp_valid; no word in flight is answered.
module radix_arithmetic_converter_core #(
   parameter int OPERAND_DIGITS = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rac_pkg::req_type req,
   output logic             busy,
   output logic             rsp_valid,
   output rac_pkg::rsp_type rsp
);
   // operand limit 10^OPERAND_DIGITS, elaboration time
   localparam longint unsigned OP_LIMIT = 64'(10) ** OPERAND_DIGITS;
   // digit count spans both operands
   localparam int DC = $clog2(2 * OPERAND_DIGITS + 1);

   rac_pkg::state_type state_ff, state_in;
   rac_pkg::req_type   req_ff, req_in;
   rac_pkg::rsp_type   rsp_ff, rsp_in;
   logic               valid_ff, valid_in;

   logic [30:0] num_ff, num_in;       // numeral being consumed
   logic [31:0] acc_ff, acc_in;       // decoded value / product
   logic [31:0] wt_ff, wt_in;         // place weight in in_base
   logic [29:0] va_ff, va_in;
   logic [29:0] vb_ff, vb_in;
   logic [30:0] res_ff, res_in;
   logic [63:0] enc_ff, enc_in;       // numeral being built
   logic [63:0] place_ff, place_in;
   logic [4:0]  cnt_ff, cnt_in;       // mul bits / encoded digit count
   logic [DC-1:0] dig_ff, dig_in;
   logic        wait_ff, wait_in;     // divide in flight
   logic [61:0] mul_ff, mul_in;       // shifted multiplicand
   logic [2:0]  err_ff, err_in;

   logic        div_start;
   logic [30:0] div_n, div_d, div_q, div_r;
   logic        div_done;

   rac_digit_divider #(.W(31)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q),
      .remainder(div_r)
   );

   function automatic logic base_ok(input logic [3:0] b);
      return (b >= 4'd2) && (b <= 4'd10);
   endfunction

   always_comb begin
      logic [63:0] sum;
      logic [35:0] prod;
      state_in  = state_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      valid_in  = 1'b0;
      num_in    = num_ff;
      acc_in    = acc_ff;
      wt_in     = wt_ff;
      va_in     = va_ff;
      vb_in     = vb_ff;
      res_in    = res_ff;
      enc_in    = enc_ff;
      place_in  = place_ff;
      cnt_in    = cnt_ff;
      dig_in    = dig_ff;
      wait_in   = wait_ff;
      mul_in    = mul_ff;
      err_in    = err_ff;
      div_start = 1'b0;
      div_n     = num_ff;
      div_d     = 31'd10;
      sum       = '0;
      prod      = '0;
      unique case (state_ff)
         rac_pkg::S_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = rac_pkg::S_CHECK;
            end
         end
         rac_pkg::S_CHECK: begin
            acc_in  = '0;
            wt_in   = 32'd1;
            dig_in  = '0;
            wait_in = 1'b0;
            num_in  = {1'b0, req_ff.operand_a};
            if (req_ff.func != rac_pkg::OP_ADD && req_ff.func != rac_pkg::OP_SUB &&
                req_ff.func != rac_pkg::OP_MUL && req_ff.func != rac_pkg::OP_DIV) begin
               err_in   = rac_pkg::ST_BAD_OP;
               state_in = rac_pkg::S_DONE;
            end else if (!base_ok(req_ff.in_base) || !base_ok(req_ff.out_base)) begin
               err_in   = rac_pkg::ST_BAD_BASE;
               state_in = rac_pkg::S_DONE;
            end else if (64'(req_ff.operand_a) >= OP_LIMIT ||
                         64'(req_ff.operand_b) >= OP_LIMIT) begin
               err_in   = rac_pkg::ST_BAD_DIGIT;
               state_in = rac_pkg::S_DONE;
            end else begin
               err_in   = rac_pkg::ST_OK;
               state_in = rac_pkg::S_DEC_A;
            end
         end
         rac_pkg::S_DEC_A, rac_pkg::S_DEC_B: begin
            // one decimal digit per divide by ten
            if (!wait_ff) begin
               if (num_ff == '0) begin
                  acc_in = '0;
                  wt_in  = 32'd1;
                  if (state_ff == rac_pkg::S_DEC_A) begin
                     va_in    = acc_ff[29:0];
                     num_in   = {1'b0, req_ff.operand_b};
                     state_in = rac_pkg::S_DEC_B;
                  end else begin
                     vb_in = acc_ff[29:0];
                     priority if (req_ff.func == rac_pkg::OP_MUL) begin
                        acc_in   = '0;
                        mul_in   = {32'd0, va_ff};
                        cnt_in   = 5'd30;
                        state_in = rac_pkg::S_MUL;
                     end else if (req_ff.func == rac_pkg::OP_DIV) begin
                        if (acc_ff[29:0] == '0) begin
                           err_in   = rac_pkg::ST_DIV_ZERO;
                           state_in = rac_pkg::S_DONE;
                        end else begin
                           state_in = rac_pkg::S_DIV;
                        end
                     end else if (req_ff.func == rac_pkg::OP_SUB) begin
                        if (acc_ff[29:0] > va_ff) begin
                           err_in   = rac_pkg::ST_NEGATIVE;
                           state_in = rac_pkg::S_DONE;
                        end else begin
                           acc_in   = 32'(va_ff - acc_ff[29:0]);
                           state_in = rac_pkg::S_RANGE;
                        end
                     end else begin
                        acc_in   = 32'(va_ff) + 32'(acc_ff[29:0]);
                        state_in = rac_pkg::S_RANGE;
                     end
                  end
               end else begin
                  div_start = 1'b1;
                  wait_in   = 1'b1;
               end
            end else if (div_done) begin
               wait_in = 1'b0;
               if (div_r[3:0] >= req_ff.in_base) begin
                  err_in   = rac_pkg::ST_BAD_DIGIT;
                  state_in = rac_pkg::S_DONE;
               end else begin
                  prod   = 36'(wt_ff) * 36'(div_r[3:0]);
                  acc_in = acc_ff + prod[31:0];
                  wt_in  = 32'(36'(wt_ff) * 36'(req_ff.in_base));
                  num_in = div_q;
                  dig_in = dig_ff + DC'(1);
               end
            end
         end
         rac_pkg::S_MUL: begin
            // shift-add, one multiplier bit per cycle; acc saturates past range
            if (vb_ff[5'd30 - cnt_ff]) begin
               sum = {32'd0, acc_ff} + {2'd0, mul_ff};
               acc_in = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            end
            if (mul_ff[61:32] != '0) begin
               mul_in = mul_ff;
            end else begin
               mul_in = {mul_ff[60:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               state_in = rac_pkg::S_RANGE;
            end
         end
         rac_pkg::S_DIV: begin
            div_n = {1'b0, va_ff};
            div_d = {1'b0, vb_ff};
            if (!wait_ff) begin
               div_start = 1'b1;
               wait_in   = 1'b1;
            end else if (div_done) begin
               wait_in  = 1'b0;
               acc_in   = {1'b0, div_q};
               state_in = rac_pkg::S_RANGE;
            end
         end
         rac_pkg::S_RANGE: begin
            if (acc_ff > {1'b0, rac_pkg::RESULT_MAX}) begin
               err_in   = rac_pkg::ST_OVERFLOW;
               state_in = rac_pkg::S_DONE;
            end else begin
               res_in   = acc_ff[30:0];
               num_in   = acc_ff[30:0];
               enc_in   = '0;
               place_in = 64'd1;
               cnt_in   = '0;
               wait_in  = 1'b0;
               state_in = rac_pkg::S_ENC;
            end
         end
         rac_pkg::S_ENC: begin
            div_d = {27'd0, req_ff.out_base};
            if (!wait_ff) begin
               if (num_ff == '0) begin
                  state_in = rac_pkg::S_DONE;
               end else if (cnt_ff == 5'(rac_pkg::NUMERAL_DIGITS)) begin
                  err_in   = rac_pkg::ST_OVERFLOW;
                  state_in = rac_pkg::S_DONE;
               end else begin
                  div_start = 1'b1;
                  wait_in   = 1'b1;
               end
            end else if (div_done) begin
               wait_in = 1'b0;
               enc_in  = enc_ff + 64'(place_ff * 64'(div_r[3:0]));
               num_in  = div_q;
               cnt_in  = cnt_ff + 5'd1;
               if (cnt_ff + 5'd1 < 5'(rac_pkg::NUMERAL_DIGITS)) begin
                  place_in = {place_ff[60:0], 3'd0} + {place_ff[62:0], 1'b0};
               end
            end
         end
         rac_pkg::S_DONE: begin
            valid_in = 1'b1;
            rsp_in   = '0;
            rsp_in.status = err_ff;
            if (err_ff == rac_pkg::ST_OK) begin
               rsp_in.value_a        = va_ff;
               rsp_in.value_b        = vb_ff;
               rsp_in.result_value   = res_ff;
               rsp_in.result_numeral = enc_ff;
            end
            state_in = rac_pkg::S_IDLE;
         end
         default: state_in = rac_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      num_ff   <= num_in;
      acc_ff   <= acc_in;
      wt_ff    <= wt_in;
      va_ff    <= va_in;
      vb_ff    <= vb_in;
      res_ff   <= res_in;
      enc_ff   <= enc_in;
      place_ff <= place_in;
      cnt_ff   <= cnt_in;
      dig_ff   <= dig_in;
      mul_ff   <= mul_in;
      err_ff   <= err_in;
      if (reset) begin
         state_ff <= rac_pkg::S_IDLE;
         valid_ff <= 1'b0;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         wait_ff  <= wait_in;
      end
   end

   assign busy      = (state_ff != rac_pkg::S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

`ifndef NO_ASSERTIONS
   // a response closes each word: sequencer is idle while rsp_valid is high
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");
   // accepting a word makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");
   // errored responses carry a zero result numeral
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status != rac_pkg::ST_OK) |-> (rsp.result_numeral == '0))
      else $error("error response with payload");
   // decoded digit count stays within 2*OPERAND_DIGITS (both operands) outside idle
   a_dig_bound: assert property (@(posedge clock) disable iff (reset)
      dig_ff <= DC'(2 * OPERAND_DIGITS) || state_ff == rac_pkg::S_IDLE)
      else $error("digit count out of range");
`endif
endmodule
